// ----- rtl/true_peak_oversampling_meter_defines.svh -----
// Assertion macros for the true-peak oversampling meter.
// Used by the top level; expects clk and arst_n in scope.
`ifndef TRUE_PEAK_OVERSAMPLING_METER_DEFINES_SVH
`define TRUE_PEAK_OVERSAMPLING_METER_DEFINES_SVH

// check a condition in the same cycle
`define TPOM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a condition in the following cycle
`define TPOM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tpom_pkg.sv -----
// Shared constants, types and tap ROM of the true-peak oversampling meter.
// No dependencies.
package tpom_pkg;

	localparam int FACTOR         = 4;
	localparam int TAPS_PER_PHASE = 8;
	localparam int COEF_WIDTH     = 18;
	localparam int TAP_COUNT      = FACTOR * TAPS_PER_PHASE;
	localparam int SAMPLE_W       = 24;
	localparam int PEAK_W         = 25;
	localparam int PHASE_W        = $clog2(FACTOR);
	localparam int TAP_W          = $clog2(TAPS_PER_PHASE);
	localparam int STEP_W         = PHASE_W + TAP_W;
	localparam int ROM_IDX_W      = $clog2(TAP_COUNT);
	localparam int PROD_W         = SAMPLE_W + COEF_WIDTH;
	localparam int ACC_W          = PROD_W + TAP_W + 1;
	localparam int COEF_FRAC      = 16;
	localparam int RND_W          = ACC_W - COEF_FRAC;
	localparam logic [PEAK_W-1:0] PEAK_MAX = '1;

	typedef logic signed [COEF_WIDTH-1:0] coef_t;
	typedef logic signed [SAMPLE_W-1:0]   sample_t;

	typedef struct packed {
		logic  vld;
		logic  first;
		logic  last;
		coef_t coef;
	} mac_ctl_t;

	typedef struct packed {
		logic              busy;
		logic [PEAK_W-1:0] peak;
	} mac_sts_t;

	function automatic coef_t tap_coef(input logic [ROM_IDX_W-1:0] idx);
		coef_t c;
		case (idx)
			5'd1:    c = -18'sd40;
			5'd2:    c = -18'sd242;
			5'd3:    c = -18'sd407;
			5'd5:    c = 18'sd1263;
			5'd6:    c = 18'sd2723;
			5'd7:    c = 18'sd2782;
			5'd9:    c = -18'sd5271;
			5'd10:   c = -18'sd10016;
			5'd11:   c = -18'sd9512;
			5'd13:   c = 18'sd18432;
			5'd14:   c = 18'sd40765;
			5'd15:   c = 18'sd58852;
			5'd16:   c = 18'sd65368;
			5'd17:   c = 18'sd57650;
			5'd18:   c = 18'sd39100;
			5'd19:   c = 18'sd17295;
			5'd21:   c = -18'sd8499;
			5'd22:   c = -18'sd8697;
			5'd23:   c = -18'sd4428;
			5'd25:   c = 18'sd2140;
			5'd26:   c = 18'sd1965;
			5'd27:   c = 18'sd834;
			5'd29:   c = -18'sd184;
			5'd30:   c = -18'sd61;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/tpom_hist_ram.sv -----
// Sample history memory: one write port, one registered read port.
// Entries read as zero until first written after reset. Depends on tpom_pkg.
module tpom_hist_ram import tpom_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [TAP_W-1:0] wr_addr,
	input  sample_t          wr_data,
	input  logic             rd_en,
	input  logic [TAP_W-1:0] rd_addr,
	output sample_t          rd_data
);

	sample_t                     mem_q [TAPS_PER_PHASE];
	logic [TAPS_PER_PHASE-1:0]   wr_vld_q;
	sample_t                     rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= wr_vld_q[rd_addr] ? mem_q[rd_addr] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= '0;
		end else if (wr_en) begin
			wr_vld_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/tpom_mac.sv -----
// Shared multiply-accumulate, magnitude rounding and block peak tracking.
// Depends on tpom_pkg.
module tpom_mac import tpom_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mac_ctl_t ctl,
	input  sample_t  rd_data,
	input  logic     peak_clr,
	output mac_sts_t sts
);

	mac_ctl_t              ctl_s1;
	logic                  vld_s2, first_s2, last_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic                  vld_s3;
	logic signed [ACC_W-1:0]  acc_s3;
	logic                  vld_s4;
	logic [ACC_W-1:0]      abs_s4;
	logic                  vld_s5;
	logic [PEAK_W-1:0]     mag_s5;
	logic [PEAK_W-1:0]     peak_q;
	logic [RND_W-1:0]      rnd;
	logic signed [ACC_W-1:0]  prod_ext;

	assign prod_ext = ACC_W'(prod_s2);
	assign rnd = abs_s4[ACC_W-1:COEF_FRAC] + RND_W'(abs_s4[COEF_FRAC-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			peak_q <= '0;
		end else begin
			ctl_s1 <= ctl;
			vld_s2 <= ctl_s1.vld;
			vld_s3 <= vld_s2 & last_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			if (peak_clr) begin
				peak_q <= '0;
			end else if (vld_s5 && mag_s5 > peak_q) begin
				peak_q <= mag_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s2 <= ctl_s1.first;
		last_s2  <= ctl_s1.last;
		prod_s2  <= rd_data * ctl_s1.coef;
		if (vld_s2) begin
			acc_s3 <= first_s2 ? prod_ext : acc_s3 + prod_ext;
		end
		abs_s4 <= acc_s3[ACC_W-1] ? ACC_W'(-acc_s3) : ACC_W'(acc_s3);
		mag_s5 <= (rnd > RND_W'(PEAK_MAX)) ? PEAK_MAX : rnd[PEAK_W-1:0];
	end

	assign sts.busy = ctl_s1.vld | vld_s2 | vld_s3 | vld_s4 | vld_s5;
	assign sts.peak = peak_q;

endmodule

// ----- rtl/true_peak_oversampling_meter.sv -----
// True-peak oversampling meter: top level with sequencer and output register.
// Takes one sample at a time: s_axis_tready stays low from accept until the shared MAC
// has walked all 32 taps, its pipeline has drained and any tlast peak has been loaded.
// Reset: asynchronous, active low; clears history (reads as zero), pointer, peak.
// Depends on tpom_pkg, tpom_hist_ram, tpom_mac and the defines header.
`include "true_peak_oversampling_meter_defines.svh"
module true_peak_oversampling_meter import tpom_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [23:0] sample
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [24:0] peak, [31:25] zero
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t              st_q;
	logic [STEP_W-1:0]   step_q;
	logic [TAP_W-1:0]    ptr_q;
	logic                last_q;
	logic                out_vld_q;
	logic [PEAK_W-1:0]   out_peak_q;
	logic                accept, out_load;
	logic [TAP_W-1:0]    k;
	logic [PHASE_W-1:0]  p;
	logic [ROM_IDX_W-1:0] rom_idx;
	mac_ctl_t            ctl;
	mac_sts_t            sts;
	sample_t             rd_data;

	assign accept = s_axis_tvalid & s_axis_tready;
	assign s_axis_tready = (st_q == ST_IDLE);
	assign k = step_q[TAP_W-1:0];
	assign p = step_q[STEP_W-1:TAP_W];
	assign rom_idx = ROM_IDX_W'((TAPS_PER_PHASE - 1 - int'(k)) * FACTOR + int'(p));

	assign ctl.vld   = (st_q == ST_RUN);
	assign ctl.first = (k == '0);
	assign ctl.last  = (k == TAP_W'(TAPS_PER_PHASE - 1));
	assign ctl.coef  = tap_coef(rom_idx);

	assign out_load = (st_q == ST_DRAIN) && !sts.busy && last_q
		&& (!out_vld_q || m_axis_tready);

	tpom_hist_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_addr (ptr_q),
		.wr_data (sample_t'(s_axis_tdata)),
		.rd_en   (st_q == ST_RUN),
		.rd_addr (ptr_q + k),
		.rd_data (rd_data)
	);

	tpom_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.rd_data  (rd_data),
		.peak_clr (out_load),
		.sts      (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			step_q    <= '0;
			ptr_q     <= '0;
			last_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						ptr_q  <= ptr_q + 1'b1;
						last_q <= s_axis_tlast;
						step_q <= '0;
						st_q   <= ST_RUN;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(TAP_COUNT - 1)) begin
						st_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!sts.busy && (!last_q || out_load)) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_peak_q <= sts.peak;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(32 - PEAK_W){1'b0}}, out_peak_q};

	`TPOM_ASSERT_NEXT(a_accept_runs, accept, st_q == ST_RUN, "accepted item did not start run")
	`TPOM_ASSERT_NOW(a_idle_quiet, s_axis_tready, !sts.busy, "MAC busy while taking input")
	`TPOM_ASSERT_NEXT(a_peak_clear, out_load, sts.peak == '0, "peak not cleared after emit")

endmodule
